// ===== sv/mvhc_pkg.sv =====
// ----------------------------------------------------------------------------
// mvhc_pkg
// Types, register map and constants of the motor valve heat controller.
// ----------------------------------------------------------------------------
package mvhc_pkg;

  typedef enum logic [2:0] {
    MODE_HOMING    = 3'd0,
    MODE_CLOSED    = 3'd1,
    MODE_OPENING   = 3'd2,
    MODE_FIN_OPEN  = 3'd3,
    MODE_OPEN      = 3'd4,
    MODE_CLOSING   = 3'd5,
    MODE_FIN_CLOSE = 3'd6,
    MODE_FAULT     = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_FWD  = 2'd1,
    DRV_BACK = 2'd2
  } drv_e;

  typedef enum logic [2:0] {
    REG_SETTLE       = 3'd0,
    REG_OPEN_FINISH  = 3'd1,
    REG_CLOSE_FINISH = 3'd2,
    REG_HOME_MIN     = 3'd3,
    REG_HOME_TIMEOUT = 3'd4,
    REG_MAX_HEAT     = 3'd5,
    REG_TEMP_LIMIT   = 3'd6,
    REG_SENSOR       = 3'd7
  } reg_e;

  localparam int unsigned AddrW  = 5;
  localparam int unsigned TimerW = 16;
  localparam int unsigned HeatW  = 26;

  localparam logic [TimerW-1:0] SettleRst       = 16'd1000;
  localparam logic [TimerW-1:0] OpenFinishRst   = 16'd500;
  localparam logic [TimerW-1:0] CloseFinishRst  = 16'd700;
  localparam logic [TimerW-1:0] HomeMinRst      = 16'd1000;
  localparam logic [TimerW-1:0] HomeTimeoutRst  = 16'd12000;
  localparam logic [HeatW-1:0]  MaxHeatRst      = 26'd43200000;
  localparam logic [7:0]        TempLimitRst    = 8'd85;

  localparam logic [23:0] LedGreen  = 24'h00FF00;
  localparam logic [23:0] LedCyan   = 24'h00FFFF;
  localparam logic [23:0] LedYellow = 24'hFFFF00;
  localparam logic [23:0] LedOrange = 24'hFF8000;
  localparam logic [23:0] LedRed    = 24'hFF0000;
  localparam logic [23:0] LedMask   = 24'hFCFCFC;

  function automatic logic [23:0] led_quarter(input logic [23:0] color);
    logic [23:0] masked;
    masked = color & LedMask;
    return masked >> 2;
  endfunction

endpackage

// ===== sv/motor_valve_heat_controller_unit.sv =====
// ----------------------------------------------------------------------------
// motor_valve_heat_controller_unit
// Valve homing, open/close sequencing and heat guards, one tick per request.
// ----------------------------------------------------------------------------
// Each request on the s_axis channel is one control tick. It advances the run,
// finish and heat timers, updates the valve mode and motor drive, and yields
// exactly one result on the m_axis channel with drive, mode, flags and the
// dimmed status color. A tick is taken when offered while ready, and its
// result appears in the next cycle; a new tick is taken every cycle while the
// receiver keeps up. The result register is the only stage, so when the
// receiver stalls the block keeps taking ticks only if the waiting result is
// drained in the same cycle, and otherwise holds off the sender.
// The APB port sets the timing, heat and temperature limits; write it only
// while no tick is in flight. Reset restores the register defaults, starts
// homing with the motor closing and empties the result register. Homing
// ends closed at the limit or in a fault that holds until the next reset.
module motor_valve_heat_controller_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // elapsed_ms[7:0], heat_request[8], limit_active[9], temp_sixteenths[22:10]
  input  logic [23:0]                 s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // motor_drive[1:0], valve_mode[4:2], over_temp[5], heat_granted[6],
  // led_rgb[30:7]
  output logic [31:0]                 m_axis_tdata_o,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [mvhc_pkg::AddrW-1:0]  paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);

  logic [15:0] settle_q, open_fin_q, close_fin_q, home_min_q, home_to_q;
  logic [25:0] max_heat_q;
  logic [7:0]  temp_limit_q;
  logic        sensor_q;

  mvhc_pkg::mode_e mode_q, mode_d;
  mvhc_pkg::drv_e  drv_q, drv_d;
  logic [15:0] run_q, run_d, fin_q, fin_d;
  logic [25:0] heat_q, heat_d;
  logic        over_d, want_d;
  logic [23:0] color_d;

  logic        out_valid_q;
  logic [31:0] out_data_q;
  logic        accept;
  logic        cfg_wr;
  mvhc_pkg::reg_e cfg_sel;

  logic [7:0]         elapsed;
  logic               req, lim;
  logic signed [12:0] temp;
  logic [16:0]        run_sum, fin_sum;
  logic [26:0]        heat_sum;
  logic [15:0]        run_g, fin_g;
  logic [25:0]        heat_g;
  logic signed [17:0] lhs, rhs;
  logic               at_lim;

  assign pready_o        = 1'b1;
  assign cfg_wr          = psel_i & penable_i & pwrite_i;
  assign cfg_sel         = mvhc_pkg::reg_e'(paddr_i[4:2]);
  assign s_axis_tready_o = ~out_valid_q | m_axis_tready_i;
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    case (cfg_sel)
      mvhc_pkg::REG_SETTLE:       prdata_o = {16'd0, settle_q};
      mvhc_pkg::REG_OPEN_FINISH:  prdata_o = {16'd0, open_fin_q};
      mvhc_pkg::REG_CLOSE_FINISH: prdata_o = {16'd0, close_fin_q};
      mvhc_pkg::REG_HOME_MIN:     prdata_o = {16'd0, home_min_q};
      mvhc_pkg::REG_HOME_TIMEOUT: prdata_o = {16'd0, home_to_q};
      mvhc_pkg::REG_MAX_HEAT:     prdata_o = {6'd0, max_heat_q};
      mvhc_pkg::REG_TEMP_LIMIT:   prdata_o = {24'd0, temp_limit_q};
      mvhc_pkg::REG_SENSOR:       prdata_o = {31'd0, sensor_q};
      default:                    prdata_o = 32'd0;
    endcase
  end

  assign elapsed  = s_axis_tdata_i[7:0];
  assign req      = s_axis_tdata_i[8];
  assign lim      = s_axis_tdata_i[9];
  assign temp     = $signed(s_axis_tdata_i[22:10]);
  assign run_sum  = {1'b0, run_q} + {9'd0, elapsed};
  assign fin_sum  = {1'b0, fin_q} + {9'd0, elapsed};
  assign heat_sum = {1'b0, heat_q} + {19'd0, elapsed};
  assign run_g    = run_sum[16] ? 16'hFFFF : run_sum[15:0];
  assign fin_g    = fin_sum[16] ? 16'hFFFF : fin_sum[15:0];
  assign heat_g   = heat_sum[26] ? 26'h3FFFFFF : heat_sum[25:0];
  assign lhs      = 18'(temp) * 18'sd9;
  assign rhs      = ($signed({10'd0, temp_limit_q}) - 18'sd32) * 18'sd80;

  always_comb begin
    mode_d = mode_q;
    drv_d  = drv_q;
    run_d  = run_g;
    fin_d  = fin_g;
    heat_d = heat_g;
    over_d = 1'b0;
    want_d = 1'b0;
    at_lim = 1'b0;
    if (mode_q == mvhc_pkg::MODE_HOMING) begin
      at_lim = (run_g > settle_q) & lim;
      if (run_g >= home_to_q) begin
        mode_d = mvhc_pkg::MODE_FAULT;
        drv_d  = mvhc_pkg::DRV_STOP;
      end else if (run_g >= home_min_q && at_lim) begin
        mode_d = mvhc_pkg::MODE_CLOSED;
        drv_d  = mvhc_pkg::DRV_STOP;
      end
    end else if (mode_q != mvhc_pkg::MODE_FAULT) begin
      want_d = req;
      if (!req) begin
        heat_d = '0;
      end
      if (want_d && sensor_q && lhs > rhs) begin
        want_d = 1'b0;
        over_d = 1'b1;
      end
      if (want_d && heat_d > max_heat_q) begin
        want_d = 1'b0;
      end
      if (!want_d) begin
        if (!(mode_q inside {mvhc_pkg::MODE_CLOSED, mvhc_pkg::MODE_CLOSING,
                             mvhc_pkg::MODE_FIN_CLOSE})) begin
          drv_d  = mvhc_pkg::DRV_BACK;
          run_d  = '0;
          mode_d = mvhc_pkg::MODE_CLOSING;
        end
      end else begin
        if (!(mode_q inside {mvhc_pkg::MODE_OPEN, mvhc_pkg::MODE_OPENING,
                             mvhc_pkg::MODE_FIN_OPEN})) begin
          drv_d  = mvhc_pkg::DRV_FWD;
          run_d  = '0;
          mode_d = mvhc_pkg::MODE_OPENING;
        end
      end
      at_lim = (run_d > settle_q) & lim;
      if (at_lim) begin
        case (mode_d)
          mvhc_pkg::MODE_OPENING: begin
            fin_d  = '0;
            mode_d = mvhc_pkg::MODE_FIN_OPEN;
          end
          mvhc_pkg::MODE_FIN_OPEN: begin
            if (fin_g > open_fin_q) begin
              mode_d = mvhc_pkg::MODE_OPEN;
              drv_d  = mvhc_pkg::DRV_STOP;
            end
          end
          mvhc_pkg::MODE_CLOSING: begin
            fin_d  = '0;
            mode_d = mvhc_pkg::MODE_FIN_CLOSE;
          end
          mvhc_pkg::MODE_FIN_CLOSE: begin
            if (fin_g > close_fin_q) begin
              mode_d = mvhc_pkg::MODE_CLOSED;
              drv_d  = mvhc_pkg::DRV_STOP;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (mode_d)
      mvhc_pkg::MODE_HOMING: color_d = mvhc_pkg::LedCyan;
      mvhc_pkg::MODE_CLOSED: color_d = over_d ? mvhc_pkg::LedCyan : mvhc_pkg::LedGreen;
      mvhc_pkg::MODE_OPEN:   color_d = mvhc_pkg::LedOrange;
      mvhc_pkg::MODE_FAULT:  color_d = mvhc_pkg::LedRed;
      default:               color_d = mvhc_pkg::LedYellow;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= mvhc_pkg::MODE_HOMING;
      drv_q       <= mvhc_pkg::DRV_BACK;
      run_q       <= '0;
      fin_q       <= '0;
      heat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q      <= mode_d;
        drv_q       <= drv_d;
        run_q       <= run_d;
        fin_q       <= fin_d;
        heat_q      <= heat_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {1'b0, mvhc_pkg::led_quarter(color_d), want_d, over_d,
                     mode_d, drv_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q     <= mvhc_pkg::SettleRst;
      open_fin_q   <= mvhc_pkg::OpenFinishRst;
      close_fin_q  <= mvhc_pkg::CloseFinishRst;
      home_min_q   <= mvhc_pkg::HomeMinRst;
      home_to_q    <= mvhc_pkg::HomeTimeoutRst;
      max_heat_q   <= mvhc_pkg::MaxHeatRst;
      temp_limit_q <= mvhc_pkg::TempLimitRst;
      sensor_q     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_sel)
        mvhc_pkg::REG_SETTLE:       settle_q     <= pwdata_i[15:0];
        mvhc_pkg::REG_OPEN_FINISH:  open_fin_q   <= pwdata_i[15:0];
        mvhc_pkg::REG_CLOSE_FINISH: close_fin_q  <= pwdata_i[15:0];
        mvhc_pkg::REG_HOME_MIN:     home_min_q   <= pwdata_i[15:0];
        mvhc_pkg::REG_HOME_TIMEOUT: home_to_q    <= pwdata_i[15:0];
        mvhc_pkg::REG_MAX_HEAT:     max_heat_q   <= pwdata_i[25:0];
        mvhc_pkg::REG_TEMP_LIMIT:   temp_limit_q <= pwdata_i[7:0];
        mvhc_pkg::REG_SENSOR:       sensor_q     <= pwdata_i[0];
        default: begin
        end
      endcase
    end
  end

endmodule
